// ===== src/mcpg_pkg.sv =====
// Shared types and constants for the midpoint circle pixel generator.
// No dependencies; used by mcpg_ctrl, mcpg_datapath and the top level.
package mcpg_pkg;

  localparam int COORD_BITS  = 13;
  localparam int RADIUS_BITS = 6;
  localparam int STEP_BITS   = 7;
  localparam int ERR_BITS    = 12;
  localparam int ADDR_BITS   = 24;
  localparam int WORD_BITS   = 32;
  localparam int CFG_BITS    = 13;
  localparam int CFG_IDX_BITS = 3;
  localparam int PIXELS      = 8;
  localparam int IN_BITS     = 96;
  localparam int OUT_BITS    = 264;

  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_VIEW_LEFT   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_VIEW_RIGHT  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_VIEW_TOP    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_VIEW_BOTTOM = 3'd4;

  localparam logic [CFG_BITS-1:0] RST_FRAME_WIDTH = 13'd640;
  localparam logic [CFG_BITS-1:0] RST_VIEW_RIGHT  = 13'd640;
  localparam logic [CFG_BITS-1:0] RST_VIEW_BOTTOM = 13'd480;

  // Column / row selectors per pixel.
  // col: 0 cx+x, 1 cx-x, 2 cx+y, 3 cx-y ; row: 0 cy+y, 1 cy-y, 2 cy+x, 3 cy-x
  localparam logic [1:0] PIX_COL [PIXELS] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3, 2'd3};
  localparam logic [1:0] PIX_ROW [PIXELS] = '{2'd0, 2'd1, 2'd0, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_CENTER,
    ST_MUL_RADIUS,
    ST_SETUP,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic load;
    logic mul_center;
    logic mul_radius;
    logic setup;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic out_valid;
    logic final_step;
  } status_t;

endpackage

// ===== src/mcpg_ctrl.sv =====
// Controller state machine for the midpoint circle pixel generator.
// Depends on mcpg_pkg; drives mcpg_datapath through cmd_t, reads status_t.
module mcpg_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic              m_tready,
  input  mcpg_pkg::status_t status,
  output mcpg_pkg::cmd_t    cmd
);

  mcpg_pkg::state_t state;
  mcpg_pkg::state_t state_next;
  logic             can_emit;

  assign can_emit = !status.out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mcpg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mcpg_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = mcpg_pkg::ST_MUL_CENTER;
      end
      mcpg_pkg::ST_MUL_CENTER: state_next = mcpg_pkg::ST_MUL_RADIUS;
      mcpg_pkg::ST_MUL_RADIUS: state_next = mcpg_pkg::ST_SETUP;
      mcpg_pkg::ST_SETUP:      state_next = mcpg_pkg::ST_RUN;
      mcpg_pkg::ST_RUN: begin
        if (can_emit && status.final_step) state_next = mcpg_pkg::ST_IDLE;
      end
      default: state_next = mcpg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      mcpg_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      mcpg_pkg::ST_MUL_CENTER: cmd.mul_center = 1'b1;
      mcpg_pkg::ST_MUL_RADIUS: cmd.mul_radius = 1'b1;
      mcpg_pkg::ST_SETUP:      cmd.setup      = 1'b1;
      mcpg_pkg::ST_RUN:        cmd.step       = can_emit;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== src/mcpg_datapath.sv =====
// Datapath: config registers, held request, midpoint step registers,
// incremental row bases and the output word register. Depends on mcpg_pkg.
module mcpg_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wen,
  input  logic [mcpg_pkg::CFG_IDX_BITS-1:0]     cfg_addr,
  input  logic [mcpg_pkg::CFG_BITS-1:0]         cfg_data,
  input  logic [mcpg_pkg::IN_BITS-1:0]          s_tdata,
  input  logic                                  m_tready,
  input  mcpg_pkg::cmd_t                        cmd,
  output mcpg_pkg::status_t                     status,
  output logic [mcpg_pkg::OUT_BITS-1:0]         m_tdata,
  output logic                                  m_tlast
);

  localparam int CB = mcpg_pkg::COORD_BITS;
  localparam int SB = mcpg_pkg::STEP_BITS;
  localparam int EB = mcpg_pkg::ERR_BITS;
  localparam int AB = mcpg_pkg::ADDR_BITS;
  localparam int WB = mcpg_pkg::WORD_BITS;
  localparam int PB = CB + 1;  // pixel coordinate
  localparam int VB = CB + 2;  // compare width

  logic [CB-1:0] frame_width, view_left, view_right, view_top, view_bottom;

  logic signed [CB-1:0] center_x, center_y;
  logic [WB-1:0]        color, depth;
  logic [SB-1:0]        step_x, step_y;
  logic signed [EB-1:0] error_term;
  logic [AB-1:0]        center_base, radius_off;
  logic [AB-1:0]        row_base [4];

  logic [AB-1:0]        out_addr [mcpg_pkg::PIXELS];
  logic [mcpg_pkg::PIXELS-1:0] out_mask;
  logic [WB-1:0]        out_color, out_depth;
  logic                 out_last, out_valid;

  // step arithmetic
  logic                 err_pos;
  logic [SB-1:0]        step_x_next, step_y_next;
  logic signed [EB-1:0] error_term_next;
  logic signed [EB-1:0] diff_xy;
  logic [AB-1:0]        fw_ext;

  // pixel evaluation
  logic signed [PB-1:0] col [4];
  logic signed [PB-1:0] row [4];
  logic [3:0]           col_in, row_in;
  logic [AB-1:0]        pix_addr [mcpg_pkg::PIXELS];
  logic [mcpg_pkg::PIXELS-1:0] pix_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= mcpg_pkg::RST_FRAME_WIDTH;
      view_left   <= '0;
      view_right  <= mcpg_pkg::RST_VIEW_RIGHT;
      view_top    <= '0;
      view_bottom <= mcpg_pkg::RST_VIEW_BOTTOM;
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        mcpg_pkg::REG_FRAME_WIDTH: frame_width <= cfg_data;
        mcpg_pkg::REG_VIEW_LEFT:   view_left   <= cfg_data;
        mcpg_pkg::REG_VIEW_RIGHT:  view_right  <= cfg_data;
        mcpg_pkg::REG_VIEW_TOP:    view_top    <= cfg_data;
        mcpg_pkg::REG_VIEW_BOTTOM: view_bottom <= cfg_data;
        default: ;
      endcase
    end
  end

  assign fw_ext  = {{(AB-CB){1'b0}}, frame_width};
  assign err_pos = (error_term > 0);
  assign diff_xy = $signed({{(EB-SB){1'b0}}, step_y}) - $signed({{(EB-SB){1'b0}}, step_x});

  always_comb begin
    step_y_next = step_y + SB'(1);
    if (err_pos) begin
      step_x_next     = step_x - SB'(1);
      error_term_next = error_term + (diff_xy <<< 2) + EB'(10);
    end else begin
      step_x_next     = step_x;
      error_term_next = error_term + $signed({{(EB-SB-2){1'b0}}, step_y, 2'b00}) + EB'(6);
    end
  end

  // x steps below zero only on a zero radius, which ends after one word
  assign status.final_step = (step_x_next < step_y_next) || (err_pos && step_x == '0);
  assign status.out_valid  = out_valid;

  // held request, step state and row bases
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      center_x   <= s_tdata[CB-1:0];
      center_y   <= s_tdata[2*CB-1:CB];
      color      <= s_tdata[2*CB+mcpg_pkg::RADIUS_BITS+WB-1:2*CB+mcpg_pkg::RADIUS_BITS];
      depth      <= s_tdata[mcpg_pkg::IN_BITS-1:mcpg_pkg::IN_BITS-WB];
      step_x     <= {1'b0, s_tdata[2*CB+mcpg_pkg::RADIUS_BITS-1:2*CB]};
      step_y     <= '0;
      error_term <= EB'(3) - $signed({{(EB-mcpg_pkg::RADIUS_BITS-1){1'b0}},
                     s_tdata[2*CB+mcpg_pkg::RADIUS_BITS-1:2*CB], 1'b0});
    end
    if (cmd.mul_center) begin
      center_base <= AB'(center_y) * fw_ext;
    end
    if (cmd.mul_radius) begin
      radius_off <= AB'(step_x) * fw_ext;
    end
    if (cmd.setup) begin
      row_base[0] <= center_base;
      row_base[1] <= center_base;
      row_base[2] <= center_base + radius_off;
      row_base[3] <= center_base - radius_off;
    end
    if (cmd.step) begin
      step_x      <= step_x_next;
      step_y      <= step_y_next;
      error_term  <= error_term_next;
      row_base[0] <= row_base[0] + fw_ext;
      row_base[1] <= row_base[1] - fw_ext;
      if (err_pos) begin
        row_base[2] <= row_base[2] - fw_ext;
        row_base[3] <= row_base[3] + fw_ext;
      end
    end
  end

  always_comb begin
    col[0] = PB'(center_x) + $signed(PB'(step_x));
    col[1] = PB'(center_x) - $signed(PB'(step_x));
    col[2] = PB'(center_x) + $signed(PB'(step_y));
    col[3] = PB'(center_x) - $signed(PB'(step_y));
    row[0] = PB'(center_y) + $signed(PB'(step_y));
    row[1] = PB'(center_y) - $signed(PB'(step_y));
    row[2] = PB'(center_y) + $signed(PB'(step_x));
    row[3] = PB'(center_y) - $signed(PB'(step_x));
    for (int i = 0; i < 4; i++) begin
      col_in[i] = (VB'(col[i]) >= $signed({2'b00, view_left})) &&
                  (VB'(col[i]) <  $signed({2'b00, view_right}));
      row_in[i] = (VB'(row[i]) >= $signed({2'b00, view_top})) &&
                  (VB'(row[i]) <  $signed({2'b00, view_bottom}));
    end
    for (int k = 0; k < mcpg_pkg::PIXELS; k++) begin
      pix_mask[k] = col_in[mcpg_pkg::PIX_COL[k]] && row_in[mcpg_pkg::PIX_ROW[k]];
      pix_addr[k] = pix_mask[k] ?
                    row_base[mcpg_pkg::PIX_ROW[k]] + AB'(col[mcpg_pkg::PIX_COL[k]]) : '0;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.step) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      out_addr  <= pix_addr;
      out_mask  <= pix_mask;
      out_color <= color;
      out_depth <= depth;
      out_last  <= status.final_step;
    end
  end

  assign m_tdata = {out_depth, out_color, out_mask,
                    out_addr[7], out_addr[6], out_addr[5], out_addr[4],
                    out_addr[3], out_addr[2], out_addr[1], out_addr[0]};
  assign m_tlast = out_last;

endmodule

// ===== src/midpoint_circle_pixel_generator.sv =====
// Top level of the midpoint circle pixel generator.
// Depends on mcpg_pkg, mcpg_ctrl and mcpg_datapath.
//
// Usage:
//   The slave stream takes one circle request per word. The master stream
//   returns one word per midpoint step with the eight symmetric pixel
//   addresses (row * frame_width + column, modulo 2^24), a viewport mask,
//   colour and depth; tlast marks the final step of a circle. Pixels outside
//   the viewport carry address 0 and a clear mask bit.
//   After a request is accepted, the centre multiply, the radius multiply and
//   setup states build the row bases; the first step registers the first word.
//   A circle of radius r yields about r/sqrt2 + 1 words, one per cycle while
//   m_tready is high. The next request is taken once the last word is registered.
//   The step loop is the single x/y/error register set plus the row-base
//   accumulators, advanced once per emitted word.
//   When the receiver stalls, the output word holds and the step loop waits.
//   Reset (rst, synchronous) empties the output register, returns to idle and
//   loads the viewport registers with their defaults (640 wide, 640 x 480).
//   Configuration is written through cfg_wen/cfg_addr/cfg_data while idle.
module midpoint_circle_pixel_generator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wen,
  input  logic [mcpg_pkg::CFG_IDX_BITS-1:0]   cfg_addr,
  input  logic [mcpg_pkg::CFG_BITS-1:0]       cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // center_x[12:0], center_y[25:13], radius[31:26], pixel_color[63:32],
  // depth_word[95:64]
  input  logic [mcpg_pkg::IN_BITS-1:0]        s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // addr_0..addr_7 (24 bits each, [191:0]), write_mask[199:192],
  // out_color[231:200], out_depth[263:232]
  output logic [mcpg_pkg::OUT_BITS-1:0]       m_tdata,
  output logic                                m_tlast
);

  mcpg_pkg::cmd_t    cmd;
  mcpg_pkg::status_t status;

  mcpg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mcpg_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tdata  (s_tdata),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (status),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  assign m_tvalid = status.out_valid;

endmodule

// ===== bench/mcpg_circle_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the midpoint circle pixel generator: mirrors the config
// registers, predicts every output word of each accepted circle request and
// compares field by field. Depends on mcpg_pkg.
module mcpg_circle_checker
  import mcpg_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wen,
  input  logic [CFG_IDX_BITS-1:0] cfg_addr,
  input  logic [CFG_BITS-1:0]     cfg_data,
  input  logic                    s_tvalid,
  input  logic                    s_tready,
  // center_x, center_y, radius, pixel_color, depth_word
  input  logic [IN_BITS-1:0]      s_tdata,
  input  logic                    m_tvalid,
  input  logic                    m_tready,
  // addr_0..addr_7, write_mask, out_color, out_depth
  input  logic [OUT_BITS-1:0]     m_tdata,
  input  logic                    m_tlast,
  output int                      words_outstanding,
  output int                      mismatch_count
);

  typedef struct packed {
    logic [PIXELS-1:0][ADDR_BITS-1:0] addr;
    logic [PIXELS-1:0]                mask;
    logic [WORD_BITS-1:0]             color;
    logic [WORD_BITS-1:0]             depth;
    logic                             last;
  } circle_word_t;

  circle_word_t        pending_words [$];
  circle_word_t        head_word;
  logic [CFG_BITS-1:0] frame_width, view_left, view_right, view_top, view_bottom;

  task automatic queue_circle_words(input logic signed [COORD_BITS-1:0] cx,
                                    input logic signed [COORD_BITS-1:0] cy,
                                    input logic [RADIUS_BITS-1:0] rad,
                                    input logic [WORD_BITS-1:0] color,
                                    input logic [WORD_BITS-1:0] depth);
    int           sx, sy, err, px, py;
    int           off_x [PIXELS];
    int           off_y [PIXELS];
    logic [31:0]  lin;
    circle_word_t w;
    sx  = int'(rad);
    sy  = 0;
    err = 3 - 2 * sx;
    while (sx >= sy) begin
      // (+x,+y) (+x,-y) (-x,+y) (-x,-y) (+y,+x) (+y,-x) (-y,+x) (-y,-x)
      off_x = '{sx, sx, -sx, -sx, sy, sy, -sy, -sy};
      off_y = '{sy, -sy, sy, -sy, sx, -sx, sx, -sx};
      w = '0;
      w.color = color;
      w.depth = depth;
      for (int k = 0; k < PIXELS; k++) begin
        px = int'(cx) + off_x[k];
        py = int'(cy) + off_y[k];
        if (px >= int'(view_left) && px < int'(view_right) &&
            py >= int'(view_top) && py < int'(view_bottom)) begin
          lin       = py * int'(frame_width) + px;
          w.addr[k] = lin[ADDR_BITS-1:0];
          w.mask[k] = 1'b1;
        end
      end
      if (err > 0) begin
        err = err + 4 * (sy - sx) + 10;
        sx--;
      end else begin
        err = err + 4 * sy + 6;
      end
      sy++;
      w.last = !(sx >= sy);
      pending_words.push_back(w);
    end
  endtask

  task automatic check_field(input string what, input int idx,
                             input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%s[%0d]: expected %h, got %h", what, idx, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      frame_width    = RST_FRAME_WIDTH;
      view_left      = '0;
      view_right     = RST_VIEW_RIGHT;
      view_top       = '0;
      view_bottom    = RST_VIEW_BOTTOM;
      mismatch_count = 0;
      pending_words.delete();
    end else begin
      if (cfg_wen) begin
        case (cfg_addr)
          REG_FRAME_WIDTH: frame_width = cfg_data;
          REG_VIEW_LEFT:   view_left   = cfg_data;
          REG_VIEW_RIGHT:  view_right  = cfg_data;
          REG_VIEW_TOP:    view_top    = cfg_data;
          REG_VIEW_BOTTOM: view_bottom = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        queue_circle_words(s_tdata[12:0], s_tdata[25:13], s_tdata[31:26],
                           s_tdata[63:32], s_tdata[95:64]);
      if (m_tvalid && m_tready) begin
        if (pending_words.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected output word %h last %b", m_tdata, m_tlast);
        end else begin
          head_word = pending_words.pop_front();
          for (int k = 0; k < PIXELS; k++)
            check_field("addr", k, 32'(head_word.addr[k]),
                        32'(m_tdata[ADDR_BITS*k +: ADDR_BITS]));
          check_field("write_mask", 0, 32'(head_word.mask), 32'(m_tdata[199:192]));
          check_field("out_color", 0, head_word.color, m_tdata[231:200]);
          check_field("out_depth", 0, head_word.depth, m_tdata[263:232]);
          check_field("last", 0, 32'(head_word.last), 32'(m_tlast));
        end
      end
    end
    words_outstanding <= pending_words.size();
  end

endmodule

// ===== bench/tb_midpoint_circle_pixel_generator.sv =====
`timescale 1ns / 100ps
// Top of the midpoint circle pixel generator bench: clock, reset, config
// phases, circle requests and output back-pressure; verdict from the checker.
// Depends on mcpg_pkg, mcpg_circle_checker and midpoint_circle_pixel_generator.
module tb_midpoint_circle_pixel_generator;
  import mcpg_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 8;

  logic                    clk;
  logic                    rst;
  logic                    cfg_wen;
  logic [CFG_IDX_BITS-1:0] cfg_addr;
  logic [CFG_BITS-1:0]     cfg_data;
  logic                    s_tvalid;
  logic                    s_tready;
  logic [IN_BITS-1:0]      s_tdata;
  logic                    m_tvalid;
  logic                    m_tready;
  logic [OUT_BITS-1:0]     m_tdata;
  logic                    m_tlast;

  int words_outstanding;
  int mismatch_count;
  int cycle_count = 0;
  int send_quiet;
  int recv_quiet;
  int view_l, view_r, view_t, view_b;

  midpoint_circle_pixel_generator DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  mcpg_circle_checker u_checker (
    .clk               (clk),
    .rst               (rst),
    .cfg_wen           (cfg_wen),
    .cfg_addr          (cfg_addr),
    .cfg_data          (cfg_data),
    .s_tvalid          (s_tvalid),
    .s_tready          (s_tready),
    .s_tdata           (s_tdata),
    .m_tvalid          (m_tvalid),
    .m_tready          (m_tready),
    .m_tdata           (m_tdata),
    .m_tlast           (m_tlast),
    .words_outstanding (words_outstanding),
    .mismatch_count    (mismatch_count)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_circle(input int cx,
                             input int cy,
                             input int rad,
                             input logic [WORD_BITS-1:0] color,
                             input logic [WORD_BITS-1:0] depth);
    int gap;
    if (send_quiet > 0) begin
      gap = 0;
      send_quiet--;
    end else begin
      gap = $urandom_range(0, 18);
      if ($urandom_range(0, 9) == 0)
        send_quiet = 8;
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {depth, color, RADIUS_BITS'(rad), COORD_BITS'(cy), COORD_BITS'(cx)};
    do @(posedge clk); while (!s_tready);
  endtask

  // stop sending, let every expected word come back, then let the block settle
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (words_outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_view(input int fw, input int l, input int r, input int t, input int b);
    logic [CFG_BITS-1:0]     vals [5];
    logic [CFG_IDX_BITS-1:0] regs [5];
    vals = '{CFG_BITS'(fw), CFG_BITS'(l), CFG_BITS'(r), CFG_BITS'(t), CFG_BITS'(b)};
    regs = '{REG_FRAME_WIDTH, REG_VIEW_LEFT, REG_VIEW_RIGHT, REG_VIEW_TOP, REG_VIEW_BOTTOM};
    for (int i = 0; i < 5; i++) begin
      cfg_wen  <= 1'b1;
      cfg_addr <= regs[i];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_wen <= 1'b0;
    view_l = l;
    view_r = r;
    view_t = t;
    view_b = b;
  endtask

  task automatic load_random_view();
    int fw, l, r, t, b;
    fw = $urandom_range(1, 4096);
    l  = $urandom_range(0, 4096);
    t  = $urandom_range(0, 4096);
    if ($urandom_range(0, 5) == 0) begin
      r = $urandom_range(0, l);
      b = $urandom_range(0, t);
    end else begin
      r = l + $urandom_range(1, 700);
      b = t + $urandom_range(1, 700);
      r = (r > 4096) ? 4096 : r;
      b = (b > 4096) ? 4096 : b;
    end
    load_view(fw, l, r, t, b);
  endtask

  // mostly centers near the viewport so the mask sees partial clipping
  task automatic send_random_circle();
    int lo_x, hi_x, lo_y, hi_y, cx, cy;
    if ($urandom_range(0, 3) != 0 && view_r > view_l && view_b > view_t) begin
      lo_x = (view_l - 70 < -4096) ? -4096 : view_l - 70;
      hi_x = (view_r + 70 > 4095) ? 4095 : view_r + 70;
      lo_y = (view_t - 70 < -4096) ? -4096 : view_t - 70;
      hi_y = (view_b + 70 > 4095) ? 4095 : view_b + 70;
      cx   = lo_x + int'($urandom_range(0, hi_x - lo_x));
      cy   = lo_y + int'($urandom_range(0, hi_y - lo_y));
    end else begin
      cx = int'($urandom_range(0, 8191)) - 4096;
      cy = int'($urandom_range(0, 8191)) - 4096;
    end
    send_circle(cx, cy, int'($urandom_range(0, 63)), $urandom, $urandom);
  endtask

  initial begin
    int gap;
    m_tready = 1'b0;
    recv_quiet = 0;
    repeat (6) @(posedge clk);
    forever begin
      if (recv_quiet > 0) begin
        gap = 0;
        recv_quiet--;
      end else begin
        gap = $urandom_range(0, 18);
        if ($urandom_range(0, 15) == 0)
          recv_quiet = 60;
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  initial begin
    rst        = 1'b1;
    cfg_wen    = 1'b0;
    cfg_addr   = REG_FRAME_WIDTH;
    cfg_data   = '0;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    send_quiet = 0;
    view_l     = 0;
    view_r     = int'(RST_VIEW_RIGHT);
    view_t     = 0;
    view_b     = int'(RST_VIEW_BOTTOM);
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset viewport 640 x 480
    send_circle(100, 100, 10, 32'h0000_0000, 32'hFFFF_FFFF);
    send_circle(5, 5, 0, 32'hFFFF_FFFF, 32'h0000_0000);
    send_circle(320, 240, 63, 32'hA5A5_5A5A, 32'h1234_5678);
    send_circle(0, 0, 5, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
    send_circle(-4096, -4096, 63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_circle(4095, 4095, 63, 32'h0000_0000, 32'h0000_0000);
    send_circle(639, 479, 1, 32'h8000_0001, 32'h7FFF_FFFE);
    send_circle(-10, 470, 20, 32'h5555_5555, 32'hAAAA_AAAA);
    send_circle(600, -3, 4, 32'hAAAA_AAAA, 32'h5555_5555);

    // full 4096 x 4096 tile, top addresses
    drain();
    load_view(4096, 0, 4096, 0, 4096);
    send_circle(4095, 4095, 63, $urandom, $urandom);
    send_circle(0, 4095, 63, $urandom, $urandom);
    send_circle(2048, 2048, 63, $urandom, $urandom);
    send_circle(4032, 4032, 63, $urandom, $urandom);

    // inverted viewport
    drain();
    load_view(1, 4096, 0, 4096, 0);
    send_circle(100, 100, 20, $urandom, $urandom);
    send_circle(0, 0, 0, $urandom, $urandom);

    // empty viewport
    drain();
    load_view(2, 50, 50, 0, 4096);
    send_circle(50, 50, 8, $urandom, $urandom);

    // one column wide, one pixel per row
    drain();
    load_view(1, 10, 11, 0, 4096);
    send_circle(10, 100, 30, $urandom, $urandom);
    send_circle(40, 100, 30, $urandom, $urandom);

    for (int ph = 0; ph < 5; ph++) begin
      drain();
      load_random_view();
      repeat (40) send_random_circle();
    end

    drain();
    if (mismatch_count == 0 && words_outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
